FILE: src/thermocouple_code_to_temperature_top_defines.svh
// ----------------------------------------------------------------------------
// Thermocouple converter assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef THERMOCOUPLE_CODE_TO_TEMPERATURE_TOP_DEFINES_SVH
`define THERMOCOUPLE_CODE_TO_TEMPERATURE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked outside reset only
`define TCTT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tctt assertion failed");

// checked on every edge, reset included
`define TCTT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tctt assertion failed");

`else

`define TCTT_ASSERT(lbl, clk, rstn, prop)
`define TCTT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: src/tctt_pkg.sv
// ----------------------------------------------------------------------------
// tctt_pkg
// Widths, constants, stage payload types and the reciprocal slope function.
// ----------------------------------------------------------------------------
`default_nettype none

package tctt_pkg;

    localparam int ADC_BITS = 12;
    localparam int CJ_W     = 9;
    localparam int TEMP_W   = 11;
    localparam int CHAN_W   = 2;
    localparam int TYPE_W   = 2;

    localparam logic [TYPE_W-1:0] TYPE_K = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_J = 2'd1;

    localparam int OFFSET_K  = 510;
    localparam int OFFSET_J  = 515;
    localparam int SPAN_LO   = 550;
    localparam int SPAN_HI_K = 2100;
    localparam int SPAN_HI_J = 2500;
    localparam int SPAN_K    = SPAN_HI_K - SPAN_LO;
    localparam int SPAN_J    = SPAN_HI_J - SPAN_LO;

    localparam int K_ENTRIES = SPAN_K + 1;
    localparam int J_ENTRIES = SPAN_J + 1;
    localparam int ROM_DEPTH = K_ENTRIES + J_ENTRIES;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    // 1/slope in Q0.16, largest value about 65536/4.69
    localparam int RECIP_W  = 14;
    localparam int RECIP_FB = 16;
    localparam int MAG_W    = ADC_BITS;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int Q_W      = PROD_W - RECIP_FB;

    localparam int SUM_A = (Q_W + 2 > CJ_W + 1) ? Q_W + 2 : CJ_W + 1;
    localparam int SUM_W = (SUM_A > TEMP_W + 1) ? SUM_A : TEMP_W + 1;

    localparam int TEMP_MAX = 2 ** (TEMP_W - 1) - 1;
    localparam int TEMP_MIN = -(2 ** (TEMP_W - 1));

    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [CJ_W-1:0]   cj;
        logic [CHAN_W-1:0] chan;
        logic              ok;
    } t_s1;

    typedef struct packed {
        logic              neg;
        logic [Q_W-1:0]    q;
        logic [CJ_W-1:0]   cj;
        logic [CHAN_W-1:0] chan;
        logic              ok;
    } t_s2;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic [CHAN_W-1:0] chan;
        logic              ok;
    } t_res;

    function automatic logic [RECIP_W-1:0] recip_slope(input int unsigned code,
                                                       input bit is_j);
        longint unsigned e;
        longint unsigned n;
        longint unsigned u30;
        longint unsigned p30;
        longint unsigned s;
        longint unsigned q1;
        longint unsigned rem;
        longint unsigned x60;
        longint unsigned u2;
        longint unsigned r;
        longint unsigned t;
        longint unsigned b;
        longint unsigned num;
        longint unsigned rec;
        e = is_j ? longint'(SPAN_HI_J) : longint'(SPAN_HI_K);
        n = (code >= e) ? 64'd0 : e - code;
        if (is_j) begin
            if (n > SPAN_J) n = SPAN_J;
            u30 = (n << 30) / SPAN_J;
            r = 0;
            for (b = 64'd32768; b != 0; b = b >> 1) begin
                t = r | b;
                if (t * t <= u30) r = t;
            end
            p30 = (u30 * r) >> 15;
            s = (64'd630 << 30) - 64'd50 * p30;
        end else begin
            if (n > SPAN_K) n = SPAN_K;
            u30 = (n << 30) / SPAN_K;
            q1  = u30;
            rem = (n << 30) % SPAN_K;
            x60 = (q1 << 30) + ((rem << 30) / SPAN_K);
            u2  = (u30 * u30) >> 30;
            r = 0;
            for (b = 64'd4096; b != 0; b = b >> 1) begin
                t = r | b;
                if (t * t * t * t * t <= x60) r = t;
            end
            p30 = (u2 * r) >> 12;
            s = (64'd469 << 30) + 64'd41 * p30;
        end
        // round-half-up quotient by bitwise search
        num = (64'd6553600 << 30) + (s >> 1);
        rec = 0;
        for (b = 64'd1 << RECIP_FB; b != 0; b = b >> 1) begin
            t = rec | b;
            if (t * s <= num) rec = t;
        end
        return RECIP_W'(rec);
    endfunction

endpackage

`default_nettype wire

FILE: src/tctt_rom.sv
// ----------------------------------------------------------------------------
// tctt_rom
// Reciprocal slope ROM, K span then J span, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tctt_rom (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [tctt_pkg::ROM_AW-1:0]  i_addr,
    output logic      [tctt_pkg::RECIP_W-1:0] o_data
);

    logic [tctt_pkg::RECIP_W-1:0] rom_mem [tctt_pkg::ROM_DEPTH];
    logic [tctt_pkg::RECIP_W-1:0] r_data;

    initial begin
        for (int i = 0; i < tctt_pkg::ROM_DEPTH; i++) begin
            if (i < tctt_pkg::K_ENTRIES) begin
                rom_mem[i] = tctt_pkg::recip_slope(tctt_pkg::SPAN_LO + i, 1'b0);
            end else begin
                rom_mem[i] = tctt_pkg::recip_slope(
                    tctt_pkg::SPAN_LO + i - tctt_pkg::K_ENTRIES, 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom_mem[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: src/tctt_scale.sv
// ----------------------------------------------------------------------------
// tctt_scale
// Multiplies the offset-free code magnitude by the reciprocal slope.
// ----------------------------------------------------------------------------
`default_nettype none

module tctt_scale (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [tctt_pkg::RECIP_W-1:0] i_recip,
    input  wire tctt_pkg::t_s1                i_s1,
    output tctt_pkg::t_s2                     o_s2
);

    logic [tctt_pkg::PROD_W-1:0] prod;
    tctt_pkg::t_s2               n_s2;
    tctt_pkg::t_s2               r_s2;

    assign prod = tctt_pkg::PROD_W'(i_s1.mag) * tctt_pkg::PROD_W'(i_recip);

    always_comb begin
        n_s2.neg  = i_s1.neg;
        n_s2.q    = prod[tctt_pkg::PROD_W-1:tctt_pkg::RECIP_FB];
        n_s2.cj   = i_s1.cj;
        n_s2.chan = i_s1.chan;
        n_s2.ok   = i_s1.ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

FILE: src/tctt_comp.sv
// ----------------------------------------------------------------------------
// tctt_comp
// Applies sign, adds cold junction, saturates; holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tctt_comp (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire tctt_pkg::t_s2 i_s2,
    output tctt_pkg::t_res     o_res
);

    localparam int SW = tctt_pkg::SUM_W;
    localparam logic signed [SW-1:0] SAT_HI = SW'(tctt_pkg::TEMP_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(tctt_pkg::TEMP_MIN);

    logic signed [SW-1:0] mag_ext;
    logic signed [SW-1:0] delta;
    logic signed [SW-1:0] cj_ext;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sat;
    tctt_pkg::t_res       n_res;
    tctt_pkg::t_res       r_res;

    always_comb begin
        mag_ext = $signed({{(SW - tctt_pkg::Q_W){1'b0}}, i_s2.q});
        delta   = i_s2.neg ? -mag_ext : mag_ext;
        cj_ext  = $signed({{(SW - tctt_pkg::CJ_W){i_s2.cj[tctt_pkg::CJ_W-1]}}, i_s2.cj});
        sum     = delta + cj_ext;
        if (sum > SAT_HI) begin
            sat = SAT_HI;
        end else if (sum < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = sum;
        end
        n_res.temperature = i_s2.ok ? sat[tctt_pkg::TEMP_W-1:0] : '0;
        n_res.chan        = i_s2.chan;
        n_res.ok          = i_s2.ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: src/thermocouple_code_to_temperature_top.sv
// ----------------------------------------------------------------------------
// thermocouple_code_to_temperature_top
// K/J thermocouple code to compensated whole degrees, ROM reciprocal slope.
//
//   channel   direction  handshake             payload
//   input     in         i_in_valid/o_in_stall i_adc_code, i_cold_junction_temp,
//                                              i_channel
//   output    out        o_out_valid/i_out_stall o_temperature, o_channel_out,
//                                              o_valid_res
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_data (thermocouple type)
//
// One transaction per cycle while the output is not stalled; the path runs
// through the ROM read register, multiply register and add/saturate output register.
// Synchronous active-low reset empties the pipeline and sets type K; the ROM
// is constant, so there is no clearing pass.
// Empty stages fill under an output stall; the input stalls only when all
// three stages hold data and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermocouple_code_to_temperature_top_defines.svh"

module thermocouple_code_to_temperature_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [tctt_pkg::ADC_BITS-1:0] i_adc_code,
    input  wire logic signed [tctt_pkg::CJ_W-1:0] i_cold_junction_temp,
    input  wire logic [tctt_pkg::CHAN_W-1:0]   i_channel,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [tctt_pkg::TEMP_W-1:0] o_temperature,
    output logic      [tctt_pkg::CHAN_W-1:0]   o_channel_out,
    output logic                               o_valid_res,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tctt_pkg::TYPE_W-1:0]   i_cfg_data
);

    localparam int AB = tctt_pkg::ADC_BITS;
    localparam int AW = tctt_pkg::ROM_AW;

    logic [tctt_pkg::TYPE_W-1:0] r_type;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    tctt_pkg::t_s1               r_s1;
    tctt_pkg::t_s1               n_s1;
    tctt_pkg::t_s2               s2;
    tctt_pkg::t_res              res;
    logic [tctt_pkg::RECIP_W-1:0] recip;

    logic           en1;
    logic           en2;
    logic           en3;
    logic           load1;
    logic           is_j;
    logic           type_ok;
    logic [AB-1:0]  off;
    logic [AW-1:0]  span_idx;
    logic [AW-1:0]  rom_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= tctt_pkg::TYPE_K;
        end else if (i_cfg_valid) begin
            r_type <= i_cfg_data;
        end
    end

    // stage enables: a stage loads when empty or when its successor moves
    assign en3   = !r_v3 || !i_out_stall;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign load1 = en1 && i_in_valid;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // front end: offset, magnitude and ROM address
    always_comb begin
        is_j    = (r_type == tctt_pkg::TYPE_J);
        type_ok = (r_type == tctt_pkg::TYPE_K) || (r_type == tctt_pkg::TYPE_J);
        off     = is_j ? AB'(tctt_pkg::OFFSET_J) : AB'(tctt_pkg::OFFSET_K);

        if (i_adc_code < tctt_pkg::SPAN_LO) begin
            span_idx = '0;
        end else if (is_j && (i_adc_code >= tctt_pkg::SPAN_HI_J)) begin
            span_idx = AW'(tctt_pkg::SPAN_J);
        end else if (!is_j && (i_adc_code >= tctt_pkg::SPAN_HI_K)) begin
            span_idx = AW'(tctt_pkg::SPAN_K);
        end else begin
            span_idx = AW'(i_adc_code - AB'(tctt_pkg::SPAN_LO));
        end
        rom_addr = is_j ? AW'(tctt_pkg::K_ENTRIES) + span_idx : span_idx;

        n_s1.neg  = (i_adc_code < off);
        n_s1.mag  = n_s1.neg ? (off - i_adc_code) : (i_adc_code - off);
        n_s1.cj   = i_cold_junction_temp;
        n_s1.chan = i_channel;
        n_s1.ok   = type_ok;
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_s1 <= n_s1;
        end
    end

    tctt_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (load1),
        .i_addr (rom_addr),
        .o_data (recip)
    );

    tctt_scale u_scale (
        .i_clk   (i_clk),
        .i_en    (en2 && r_v1),
        .i_recip (recip),
        .i_s1    (r_s1),
        .o_s2    (s2)
    );

    tctt_comp u_comp (
        .i_clk (i_clk),
        .i_en  (en3 && r_v2),
        .i_s2  (s2),
        .o_res (res)
    );

    assign o_out_valid   = r_v3;
    assign o_temperature = $signed(res.temperature);
    assign o_channel_out = res.chan;
    assign o_valid_res   = res.ok;

    `TCTT_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)
    `TCTT_ASSERT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> r_v1)
    `TCTT_ASSERT(a_stall_when_full, i_clk, i_rst_n, o_in_stall |-> r_v1 && r_v2 && r_v3)
    `TCTT_ASSERT(a_mid_holds, i_clk, i_rst_n, r_v2 && !en2 |=> r_v2 && $stable(s2))
    `TCTT_ASSERT(a_invalid_zero, i_clk, i_rst_n, o_out_valid && !o_valid_res |-> o_temperature == '0)

endmodule

`default_nettype wire
